// ===== src/tf512_pkg.sv =====
`default_nettype none

package tf512_pkg;

    typedef logic [63:0] word_t;
    typedef logic [7:0][63:0] block_t;
    typedef logic [8:0][63:0] key_ext_t;

    localparam word_t KEY_PARITY = 64'h1BD1_1BDA_A9FC_1A22;
    localparam int unsigned KEY_WORDS = 8;

    localparam int unsigned ROT_TABLE [8][4] = '{
        '{46, 36, 19, 37},
        '{33, 27, 14, 42},
        '{17, 49, 36, 39},
        '{44,  9, 54, 56},
        '{39, 30, 34, 24},
        '{13, 50, 10, 17},
        '{25, 29, 39, 43},
        '{ 8, 35, 56, 22}
    };

    localparam int unsigned PERM_SRC [8] = '{2, 1, 4, 7, 6, 5, 0, 3};

    typedef struct packed {
        word_t plain_word_0;
        word_t plain_word_1;
        word_t plain_word_2;
        word_t plain_word_3;
        word_t plain_word_4;
        word_t plain_word_5;
        word_t plain_word_6;
        word_t plain_word_7;
        word_t tweak_low;
        word_t tweak_high;
    } plain_t;

    typedef struct packed {
        word_t cipher_word_0;
        word_t cipher_word_1;
        word_t cipher_word_2;
        word_t cipher_word_3;
        word_t cipher_word_4;
        word_t cipher_word_5;
        word_t cipher_word_6;
        word_t cipher_word_7;
    } cipher_t;

    // state word block plus the tweak that travels with it
    typedef struct packed {
        block_t w;
        word_t  t0;
        word_t  t1;
    } lane_t;

    // amounts in the table are never zero
    function automatic word_t rotl(input word_t v, input int unsigned n);
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic block_t add_words(input block_t a, input block_t b);
        block_t r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = a[i] + b[i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/tf512_key_regs.sv =====
`default_nettype none

module tf512_key_regs
    import tf512_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    output key_ext_t         kx
);

    block_t key_reg;
    logic   wr_en;
    logic [2:0] wr_idx;

    assign pready = 1'b1;
    assign wr_idx = paddr[5:3];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (wr_en)
        begin
            key_reg[wr_idx] <= pwdata;
        end
    end

    assign prdata = key_reg[wr_idx];

    always_comb
    begin
        kx[8] = KEY_PARITY;
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            kx[i] = key_reg[i];
            kx[8] = kx[8] ^ key_reg[i];
        end
    end

endmodule

`default_nettype wire

// ===== src/tf512_subkey.sv =====
`default_nettype none

module tf512_subkey
    import tf512_pkg::*;
#(
    parameter int unsigned INDEX = 0
)
(
    input  wire key_ext_t kx,
    input  wire word_t    t0,
    input  wire word_t    t1,
    output block_t        subkey
);

    word_t [2:0] tx;

    assign tx[0] = t0;
    assign tx[1] = t1;
    assign tx[2] = t0 ^ t1;

    for (genvar i = 0; i < 8; i++)
    begin : g_word
        if (i == 5)
        begin : g_t_a
            assign subkey[i] = kx[(INDEX + i) % 9] + tx[INDEX % 3];
        end
        else if (i == 6)
        begin : g_t_b
            assign subkey[i] = kx[(INDEX + i) % 9] + tx[(INDEX + 1) % 3];
        end
        else if (i == 7)
        begin : g_cnt
            assign subkey[i] = kx[(INDEX + i) % 9] + 64'(INDEX);
        end
        else
        begin : g_key
            assign subkey[i] = kx[(INDEX + i) % 9];
        end
    end

endmodule

`default_nettype wire

// ===== src/tf512_round_cell.sv =====
`default_nettype none

module tf512_round_cell
    import tf512_pkg::*;
#(
    parameter int unsigned ROUND = 0
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire key_ext_t kx,
    input  wire logic     up_valid,
    input  wire lane_t    up_data,
    output logic          up_ready,
    output logic          dn_valid,
    output lane_t         dn_data,
    input  wire logic     dn_ready
);

    localparam int unsigned ROW = ROUND % 8;

    logic   valid_reg;
    lane_t  data_reg;
    lane_t  data_next;
    block_t inj;
    block_t mixed;

    if (ROUND % 4 == 0)
    begin : g_inject
        block_t sub;
        tf512_subkey #(.INDEX(ROUND / 4)) u_subkey (
            .kx     (kx),
            .t0     (up_data.t0),
            .t1     (up_data.t1),
            .subkey (sub)
        );
        assign inj = add_words(up_data.w, sub);
    end
    else
    begin : g_pass
        assign inj = up_data.w;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mixed[2*i]   = inj[2*i] + inj[2*i+1];
            mixed[2*i+1] = rotl(inj[2*i+1], ROT_TABLE[ROW][i]) ^ mixed[2*i];
        end
        data_next.t0 = up_data.t0;
        data_next.t1 = up_data.t1;
        for (int j = 0; j < 8; j++)
        begin
            data_next.w[j] = mixed[PERM_SRC[j]];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/threefish512_block_encrypt_core.sv =====
// Threefish-512 block encryption, fully unrolled.
//
// Key: eight 64-bit words written over the APB port at byte address 8*i,
// read back the same way; pready is always high. Write keys only while no
// block is in flight.
// Input: plain_valid / plain_stall carry the eight plaintext words and the
// two tweak words; a block is taken when plain_valid is high and plain_stall
// is low. Output: cipher_valid / cipher_stall carry the eight cipher words.
// Each block passes through ROUND_COUNT round cells, then the final subkey
// add in the output register. Throughput is one block per cycle while the
// receiver does not stall; each round cell holds one block.
// When the receiver stalls, the output holds and blocks pile up behind it
// cell by cell; plain_stall rises only once every cell is full.
// Reset clears the key to zero and empties the pipeline.
`default_nettype none

module threefish512_block_encrypt_core
    import tf512_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = 72
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        plain_valid,
    output logic             plain_stall,
    input  wire plain_t      plain,
    output logic             cipher_valid,
    input  wire logic        cipher_stall,
    output cipher_t          cipher
);

    key_ext_t kx;

    lane_t  stage_data [ROUND_COUNT+1];
    logic [ROUND_COUNT:0] stage_valid;
    logic [ROUND_COUNT:0] stage_ready;

    logic    cipher_valid_reg;
    cipher_t cipher_reg;
    cipher_t cipher_next;
    block_t  final_sub;
    block_t  final_w;

    tf512_key_regs u_key_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .kx      (kx)
    );

    assign stage_valid[0] = plain_valid;
    assign stage_data[0].w[0] = plain.plain_word_0;
    assign stage_data[0].w[1] = plain.plain_word_1;
    assign stage_data[0].w[2] = plain.plain_word_2;
    assign stage_data[0].w[3] = plain.plain_word_3;
    assign stage_data[0].w[4] = plain.plain_word_4;
    assign stage_data[0].w[5] = plain.plain_word_5;
    assign stage_data[0].w[6] = plain.plain_word_6;
    assign stage_data[0].w[7] = plain.plain_word_7;
    assign stage_data[0].t0   = plain.tweak_low;
    assign stage_data[0].t1   = plain.tweak_high;
    assign plain_stall = !stage_ready[0];

    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_round
        tf512_round_cell #(.ROUND(r)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .kx       (kx),
            .up_valid (stage_valid[r]),
            .up_data  (stage_data[r]),
            .up_ready (stage_ready[r]),
            .dn_valid (stage_valid[r+1]),
            .dn_data  (stage_data[r+1]),
            .dn_ready (stage_ready[r+1])
        );
    end

    tf512_subkey #(.INDEX(ROUND_COUNT / 4)) u_final_subkey (
        .kx     (kx),
        .t0     (stage_data[ROUND_COUNT].t0),
        .t1     (stage_data[ROUND_COUNT].t1),
        .subkey (final_sub)
    );

    assign final_w = add_words(stage_data[ROUND_COUNT].w, final_sub);

    always_comb
    begin
        cipher_next.cipher_word_0 = final_w[0];
        cipher_next.cipher_word_1 = final_w[1];
        cipher_next.cipher_word_2 = final_w[2];
        cipher_next.cipher_word_3 = final_w[3];
        cipher_next.cipher_word_4 = final_w[4];
        cipher_next.cipher_word_5 = final_w[5];
        cipher_next.cipher_word_6 = final_w[6];
        cipher_next.cipher_word_7 = final_w[7];
    end

    assign stage_ready[ROUND_COUNT] = !cipher_valid_reg || !cipher_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_valid_reg <= 1'b0;
        end
        else if (stage_ready[ROUND_COUNT])
        begin
            cipher_valid_reg <= stage_valid[ROUND_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[ROUND_COUNT] && stage_valid[ROUND_COUNT])
        begin
            cipher_reg <= cipher_next;
        end
    end

    assign cipher_valid = cipher_valid_reg;
    assign cipher       = cipher_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        plain_stall |-> (cipher_valid && cipher_stall && (&stage_valid[ROUND_COUNT:1])))
        else $error("input stalled with room in the pipeline");

    a_empty_output_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !cipher_valid |-> !plain_stall)
        else $error("input stalled while output empty");

    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        (plain_valid && !plain_stall) |=> stage_valid[1])
        else $error("accepted block lost at first cell");

    a_output_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cipher_valid && cipher_stall) |=> (cipher_valid && $stable(cipher)))
        else $error("stalled output dropped or changed");

endmodule

`default_nettype wire
